@@ sv/ubfd_pkg.sv @@
// shared constants, types and the baud rate table of the serial bridge buffer
`default_nettype none

package ubfd_pkg;

  localparam int FIFO_DEPTH  = 2048;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int SHORT_LIMIT = 4;
  localparam int LONG_LIMIT  = 127;
  localparam int CNT_W       = 7;
  localparam int CMP_W       = (PTR_W > CNT_W) ? PTR_W : CNT_W;

  localparam int RATE_COUNT  = 24;
  localparam int RATE_IDX_W  = 5;
  localparam int RATE_RESET  = 17;

  localparam logic [7:0] MORE_FLAG = 8'h80;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_SHORT     = 3'd1,
    OP_LONG      = 3'd2,
    OP_RATE_UP   = 3'd3,
    OP_RATE_DOWN = 3'd4,
    OP_GET_RATE  = 3'd5,
    OP_NOP6      = 3'd6,
    OP_NOP7      = 3'd7
  } opcode_t;

  typedef struct packed {
    logic up;
    logic down;
  } rate_cmd_t;

  function automatic logic [31:0] rate_value(input logic [RATE_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd50;
      5'd1:    v = 32'd75;
      5'd2:    v = 32'd110;
      5'd3:    v = 32'd134;
      5'd4:    v = 32'd150;
      5'd5:    v = 32'd200;
      5'd6:    v = 32'd300;
      5'd7:    v = 32'd600;
      5'd8:    v = 32'd1200;
      5'd9:    v = 32'd2400;
      5'd10:   v = 32'd4800;
      5'd11:   v = 32'd9600;
      5'd12:   v = 32'd14400;
      5'd13:   v = 32'd19200;
      5'd14:   v = 32'd28800;
      5'd15:   v = 32'd38400;
      5'd16:   v = 32'd57600;
      5'd17:   v = 32'd115200;
      5'd18:   v = 32'd230400;
      5'd19:   v = 32'd460800;
      5'd20:   v = 32'd576000;
      5'd21:   v = 32'd921600;
      5'd22:   v = 32'd1843200;
      5'd23:   v = 32'd3686400;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/ubfd_ram.sv @@
// single-port-write, registered-read byte memory for the receive ring
`default_nettype none

module ubfd_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ubfd_rate.sv @@
// baud rate index with wrapping up and down steps and table lookup
`default_nettype none

module ubfd_rate
  import ubfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rate_cmd_t cmd,
  output logic [31:0]    rate
);

  logic [RATE_IDX_W-1:0] idx_r;
  logic [RATE_IDX_W-1:0] idx_nxt;
  logic [RATE_IDX_W-1:0] idx_eff;

  localparam logic [RATE_IDX_W-1:0] LAST_IDX = RATE_IDX_W'(RATE_COUNT - 1);
  localparam logic [RATE_IDX_W-1:0] COUNT_IDX = RATE_IDX_W'(RATE_COUNT);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.up) begin
      idx_nxt = (idx_r >= LAST_IDX) ? '0 : idx_r + 1'b1;
    end else if (cmd.down) begin
      idx_nxt = (idx_r == '0 || idx_r >= COUNT_IDX) ? LAST_IDX : idx_r - 1'b1;
    end
  end

  // out-of-table index folds back into range
  assign idx_eff = (idx_r >= COUNT_IDX) ? idx_r - COUNT_IDX : idx_r;
  assign rate    = rate_value(idx_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= RATE_IDX_W'(RATE_RESET);
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/uart_bridge_fifo_drain_core.sv @@
// top level: receive byte ring with burst drain replies and baud rate control
//
// in_* carries one request per handshake: opcode in tdata[2:0], byte in
// tdata[10:3]. push, rate up, rate down and unused opcodes are taken
// and give no reply. get rate gives one word of four bytes. a drain gives a
// header byte (count in 6:0, bit 7 when more bytes remain) and up to 4
// (short) or 127 (long) queued bytes, packed little-endian into 32-bit
// words on out_*, with the valid byte count in tdata[34:32] and tlast on
// the final word.
// a drain keeps the input closed until its last word is loaded into the
// output register: the registered ring read of each byte overlaps the
// capture of the byte before. get rate keeps the input closed until its
// word is loaded. requests are taken only between replies.
// reset empties the ring (pointers to zero) and sets the rate index to
// 115200 baud; the memory itself is not cleared. when the receiver stalls,
// the finished word waits in the output register and the drain holds.
`default_nettype none

module uart_bridge_fifo_drain_core
  import ubfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[2:0], rx_byte[10:3], zeros
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // data_word[31:0], bytes_valid[34:32], zeros
  output logic                        out_tlast   // last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_CAP,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [2:0]        nb_r, nb_nxt;
  logic [3:0][7:0]   word_r, word_nxt;
  logic              ov_r, ov_nxt;
  logic [31:0]       odata_r, odata_nxt;
  logic [2:0]        obv_r, obv_nxt;
  logic              olast_r, olast_nxt;

  opcode_t           op;
  logic [7:0]        rx_byte;
  logic              accept;
  logic              out_free;
  logic [PTR_W-1:0]  avail;
  logic [CMP_W-1:0]  avail_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  count;
  logic              more;

  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  rate_cmd_t         rate_cmd;
  logic [31:0]       rate;

  assign op       = opcode_t'(in_tdata[2:0]);
  assign rx_byte  = in_tdata[10:3];
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;

  assign avail     = wp_r - rp_r;
  assign lim       = (op == OP_LONG) ? CNT_W'(LONG_LIMIT) : CNT_W'(SHORT_LIMIT);
  assign avail_ext = CMP_W'(avail);
  assign lim_ext   = CMP_W'(lim);
  assign more      = avail_ext > lim_ext;
  assign count     = more ? lim : avail_ext[CNT_W-1:0];

  assign ram_we = accept && (op == OP_PUSH) && (wp_r + 1'b1 != rp_r);

  assign rate_cmd.up   = accept && (op == OP_RATE_UP);
  assign rate_cmd.down = accept && (op == OP_RATE_DOWN);

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    rem_nxt   = rem_r;
    nb_nxt    = nb_r;
    word_nxt  = word_r;
    ov_nxt    = ov_r && !out_tready;
    odata_nxt = odata_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    ram_re    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH: begin
              if (ram_we) begin
                wp_nxt = wp_r + 1'b1;
              end
            end
            OP_SHORT, OP_LONG: begin
              word_nxt    = '0;
              word_nxt[0] = (more ? MORE_FLAG : 8'h00) | {1'b0, count};
              nb_nxt      = 3'd1;
              if (count != '0) begin
                ram_re    = 1'b1;
                rp_nxt    = rp_r + 1'b1;
                rem_nxt   = count - 1'b1;
                state_nxt = S_CAP;
              end else begin
                rem_nxt   = '0;
                state_nxt = S_EMIT;
              end
            end
            OP_GET_RATE: state_nxt = S_GET;
            default: ;
          endcase
        end
      end
      S_GET: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = rate;
          obv_nxt   = 3'd4;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CAP: begin
        word_nxt[nb_r[1:0]] = ram_rdata;
        nb_nxt = nb_r + 1'b1;
        if (nb_r == 3'd3 || rem_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          ram_re  = 1'b1;
          rp_nxt  = rp_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = word_r;
          obv_nxt   = nb_r;
          olast_nxt = (rem_r == '0);
          word_nxt  = '0;
          nb_nxt    = '0;
          if (rem_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            rp_nxt    = rp_r + 1'b1;
            rem_nxt   = rem_r - 1'b1;
            state_nxt = S_CAP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      rem_r   <= '0;
      nb_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      rem_r   <= rem_nxt;
      nb_r    <= nb_nxt;
      ov_r    <= ov_nxt;
    end
    word_r  <= word_nxt;
    odata_r <= odata_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
  end

  ubfd_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  ubfd_rate u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rate_cmd),
    .rate  (rate)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_TDATA_W - 35)'(0), obv_r, odata_r};
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire
